@@ hw/rtl/csvfs_pkg.sv @@
// Shared constants and types of the CSV field splitter.
`timescale 1ns / 1ps

package csvfs_pkg;

	localparam int FIELD_DEPTH_DEF = 64;

	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	localparam logic [1:0] QUOTE_NONE = 2'd0;
	localparam logic [1:0] QUOTE_DBL  = 2'd1;
	localparam logic [1:0] QUOTE_SGL  = 2'd2;

	// Request from the input tracker to the emitter.
	typedef struct packed {
		logic       launch;
		logic       marker;
		logic       qmode;
		logic [7:0] qchar;
		logic       trunc;
		logic       line;
	} csvfs_ctl_t;

	function automatic logic is_quote(input logic [7:0] c);
		return (c == CH_DQUOTE) || (c == CH_SQUOTE);
	endfunction

endpackage

@@ hw/rtl/csvfs_field_mem.sv @@
// Field buffer: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module csvfs_field_mem #(
	parameter int FIELD_DEPTH = 64,
	localparam int AW = $clog2(FIELD_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data_s1
);

	logic [7:0] mem [FIELD_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

endmodule

@@ hw/rtl/csvfs_emit.sv @@
// Field emitter: reads the buffer back, strips quotes and escapes, drives the result port.
`timescale 1ns / 1ps

module csvfs_emit
	import csvfs_pkg::*;
#(
	parameter int FIELD_DEPTH = 64,
	localparam int AW = $clog2(FIELD_DEPTH),
	localparam int CW = $clog2(FIELD_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  csvfs_ctl_t    ctl,
	input  logic [CW-1:0] start_idx,
	input  logic [CW-1:0] end_idx,
	output logic          busy,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data_s1,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,  // [7:0] out_byte
	output logic          m_tlast,  // field_last
	output logic [2:0]    m_tuser   // [0] byte_valid, [1] line_done, [2] field_truncated
);

	typedef enum logic [2:0] {E_IDLE, E_READ, E_RUN, E_FLUSH, E_MARK} emit_state_t;

	emit_state_t   state_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] end_q;
	logic          qmode_q;
	logic [7:0]    qchar_q;
	logic          trunc_q;
	logic          line_q;
	logic          skip_q;
	logic          esc_q;
	logic [7:0]    hold_q;
	logic          hold_vld_q;

	logic          can_adv;
	logic          adv;
	logic          drop;
	logic          produce;
	logic          skip_nx;
	logic          esc_nx;
	logic          out_load;
	logic [CW-1:0] cur_inc;
	logic [CW-1:0] rd_idx;

	assign busy    = (state_q != E_IDLE);
	assign can_adv = !m_tvalid || m_tready;
	assign cur_inc = cur_q + CW'(1);
	assign adv     = (state_q == E_RUN) && (cur_q < end_q) && can_adv;
	assign rd_idx  = adv ? cur_inc : cur_q;
	assign rd_addr = rd_idx[AW-1:0];

	// A new item goes into the output register this cycle.
	assign out_load = (adv && produce && hold_vld_q) ||
	                  (((state_q == E_FLUSH) || (state_q == E_MARK)) && can_adv);

	// Collapse of doubled quotes first, then backslash removal, both on the byte in flight.
	always_comb begin
		drop    = skip_q && (rd_data_s1 == qchar_q);
		skip_nx = 1'b0;
		esc_nx  = esc_q;
		produce = 1'b0;
		if (!drop) begin
			skip_nx = qmode_q && (rd_data_s1 == qchar_q) && (cur_inc < end_q);
			if (esc_q) begin
				produce = 1'b1;
				esc_nx  = 1'b0;
			end else if (rd_data_s1 == CH_BACKSLASH) begin
				esc_nx = 1'b1;
			end else begin
				produce = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= E_IDLE;
			cur_q      <= '0;
			end_q      <= '0;
			qmode_q    <= 1'b0;
			qchar_q    <= '0;
			trunc_q    <= 1'b0;
			line_q     <= 1'b0;
			skip_q     <= 1'b0;
			esc_q      <= 1'b0;
			hold_q     <= '0;
			hold_vld_q <= 1'b0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tlast    <= 1'b0;
			m_tuser    <= '0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					if (ctl.launch) begin
						cur_q      <= start_idx;
						end_q      <= end_idx;
						qmode_q    <= ctl.qmode;
						qchar_q    <= ctl.qchar;
						trunc_q    <= ctl.trunc;
						line_q     <= ctl.line;
						skip_q     <= 1'b0;
						esc_q      <= 1'b0;
						hold_vld_q <= 1'b0;
						state_q    <= ctl.marker ? E_MARK : E_READ;
					end
				end
				E_READ: begin
					state_q <= E_RUN;
				end
				E_RUN: begin
					if (cur_q >= end_q) begin
						state_q <= E_FLUSH;
					end else if (adv) begin
						cur_q  <= cur_inc;
						skip_q <= skip_nx;
						esc_q  <= esc_nx;
						if (produce) begin
							hold_q     <= rd_data_s1;
							hold_vld_q <= 1'b1;
							// The held byte is known not to be the last one of the field.
							if (hold_vld_q) begin
								m_tdata <= hold_q;
								m_tlast <= 1'b0;
								m_tuser <= {trunc_q, 1'b0, 1'b1};
							end
						end
					end
				end
				E_FLUSH: begin
					if (can_adv) begin
						m_tdata <= hold_vld_q ? hold_q : 8'h00;
						m_tlast <= 1'b1;
						m_tuser <= {trunc_q, line_q, hold_vld_q};
						state_q <= E_IDLE;
					end
				end
				E_MARK: begin
					if (can_adv) begin
						m_tdata <= 8'h00;
						m_tlast <= 1'b0;
						m_tuser <= {1'b0, 1'b1, 1'b0};
						state_q <= E_IDLE;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/csv_field_splitter_core.sv @@
// Top level of the CSV field splitter: quote tracking, field buffering and field emission.
`timescale 1ns / 1ps

// Channel  Dir  tdata              tlast        tuser
// s_*      in   [7:0] in_byte      line_last    -
// m_*      out  [7:0] out_byte     field_last   [0] byte_valid [1] line_done [2] field_truncated
//
// Each byte but a field-ending comma or a line end inside quotes is written to the field
// memory while it has room, else field_truncated is set. A byte that ends a field starts
// the emitter, which reads the memory one entry a cycle while m_tready lets it advance.
// A line that ends inside quotes gives one marker item instead, held while m_tready is low.
// No input item is taken while the emitter is busy. Reset needs no memory clearing pass.

module csv_field_splitter_core
	import csvfs_pkg::*;
#(
	parameter int FIELD_DEPTH = FIELD_DEPTH_DEF,
	localparam int AW = $clog2(FIELD_DEPTH),
	localparam int CW = $clog2(FIELD_DEPTH + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,  // line_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast,  // field_last
	output logic [2:0] m_tuser   // [0] byte_valid, [1] line_done, [2] field_truncated
);

	logic [1:0]    quote_q;
	logic [7:0]    prev_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [7:0]    first_q;
	logic [7:0]    last_q;

	logic          accept;
	logic          busy;
	logic [7:0]    qch;
	logic          closing;
	logic          opening;
	logic [1:0]    quote_nx;
	logic          fend;
	logic          marker;
	logic          push;
	logic          push_ok;
	logic          ovf_set;
	logic [CW-1:0] n_new;
	logic [7:0]    first_new;
	logic [7:0]    last_new;
	logic          qmode;
	logic [CW-1:0] start_idx;
	logic [CW-1:0] end_idx;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_s1;
	csvfs_ctl_t    ctl;

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		case (quote_q)
			QUOTE_DBL: qch = CH_DQUOTE;
			QUOTE_SGL: qch = CH_SQUOTE;
			default:   qch = 8'h00;
		endcase
		closing  = (quote_q != QUOTE_NONE) && (s_tdata == qch) && (prev_q != CH_BACKSLASH);
		opening  = (quote_q == QUOTE_NONE) && is_quote(s_tdata);
		if (closing) begin
			quote_nx = QUOTE_NONE;
		end else if (opening) begin
			quote_nx = (s_tdata == CH_DQUOTE) ? QUOTE_DBL : QUOTE_SGL;
		end else begin
			quote_nx = quote_q;
		end
		fend      = (quote_nx == QUOTE_NONE) && ((s_tdata == CH_COMMA) || s_tlast);
		marker    = !fend && s_tlast;
		push      = fend ? (s_tdata != CH_COMMA) : !s_tlast;
		push_ok   = push && (cnt_q < CW'(FIELD_DEPTH));
		ovf_set   = push && !push_ok;
		n_new     = cnt_q + CW'(push_ok);
		first_new = (push_ok && (cnt_q == '0)) ? s_tdata : first_q;
		last_new  = push_ok ? s_tdata : last_q;
		// Enclosing quotes need two kept bytes, both the same quote character.
		qmode     = (n_new > CW'(1)) && (first_new == last_new) && is_quote(first_new);
		start_idx = qmode ? CW'(1) : '0;
		end_idx   = qmode ? (n_new - CW'(1)) : n_new;

		ctl.launch = accept && (fend || marker);
		ctl.marker = marker;
		ctl.qmode  = qmode;
		ctl.qchar  = first_new;
		ctl.trunc  = ovf_q || ovf_set;
		ctl.line   = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QUOTE_NONE;
			prev_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (fend || marker) begin
				quote_q <= QUOTE_NONE;
				prev_q  <= s_tlast ? 8'h00 : s_tdata;
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				quote_q <= quote_nx;
				prev_q  <= s_tdata;
				cnt_q   <= n_new;
				ovf_q   <= ovf_q || ovf_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= first_new;
			last_q  <= last_new;
		end
	end

	csvfs_field_mem #(
		.FIELD_DEPTH(FIELD_DEPTH)
	) u_mem (
		.clk       (clk),
		.wr_en     (accept && push_ok),
		.wr_addr   (cnt_q[AW-1:0]),
		.wr_data   (s_tdata),
		.rd_addr   (rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	csvfs_emit #(
		.FIELD_DEPTH(FIELD_DEPTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.start_idx (start_idx),
		.end_idx   (end_idx),
		.busy      (busy),
		.rd_addr   (rd_addr),
		.rd_data_s1(rd_data_s1),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FIELD_DEPTH))
		else $error("field count beyond buffer depth");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> (cnt_q == '0) && (quote_q == QUOTE_NONE))
		else $error("line end did not clear the field state");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0] || (m_tuser[1] && !m_tuser[2]))
		else $error("result without field end is neither a byte nor a line marker");

	a_line_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tuser[1] |-> m_tlast)
		else $error("line end flagged on a byte that does not end its field");

endmodule
